// File: hw/rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the sorter RTL.
// Pulled in by the modules that check their own control logic; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked implication, disabled while the active-low reset is asserted
`define ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

`endif

// File: hw/rtl/bis_pkg.sv
// bis_pkg: types, codes and sizes for the binary insertion sorter.
// No dependencies; imported by every sorter module.
package bis_pkg;

  // Default store capacity
  localparam int unsigned CAPACITY_DEF = 1024;

  // Field widths
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 32;

  // Command queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);

  // Item kind codes on tuser
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  entry_value;
  } res_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SEARCH,
    BS_COMPARE,
    BS_SHIFT,
    BS_SHIFT_LAST,
    BS_PLACE,
    BS_READ_WAIT,
    BS_DONE
  } back_state_e;

endpackage

// File: hw/rtl/bis_front.sv
// bis_front: input beat register and kind decode for the sorter.
// Depends on bis_pkg; feeds the command queue.
module bis_front import bis_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,  // value[15:0], index[25:16], zero pad
  input  logic [KIND_W-1:0]     s_axis_tuser_i,  // kind[1:0]
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o,
  input  logic                  cmd_ready_i
);

  logic cmd_valid_q, cmd_valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  // Map the kind code onto an operation; unused codes do nothing
  function automatic op_e decode_kind(input logic [KIND_W-1:0] kind);
    op_e op;
    case (kind)
      KIND_INSERT: op = OP_INSERT;
      KIND_READ:   op = OP_READ;
      KIND_CLEAR:  op = OP_CLEAR;
      default:     op = OP_NOP;
    endcase
    return op;
  endfunction

  assign s_axis_tready_o = !cmd_valid_q || cmd_ready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Stage register: load on an input beat, empty when the queue takes it
  always_comb begin
    cmd_valid_d = cmd_valid_q;
    cmd_d       = cmd_q;
    if (accept) begin
      cmd_valid_d = 1'b1;
      cmd_d.op    = decode_kind(s_axis_tuser_i);
      cmd_d.value = s_axis_tdata_i[VALUE_W-1:0];
      cmd_d.index = s_axis_tdata_i[VALUE_W +: INDEX_W];
    end else if (cmd_ready_i) begin
      cmd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

// File: hw/rtl/bis_fifo.sv
// bis_fifo: short command queue between the sorter front and back.
// Depends on bis_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bis_fifo import bis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_o,
  input  logic pop_ready_i
);

  cmd_t               buf_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FIFO_PW:0]   cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = cnt_q != (FIFO_PW+1)'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_o        = buf_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wp_d  = push ? FIFO_PW'(wp_q + 1'b1) : wp_q;
    rp_d  = pop  ? FIFO_PW'(rp_q + 1'b1) : rp_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = (FIFO_PW+1)'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = (FIFO_PW+1)'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= push_i;
    end
  end

  `ASSERT_CLK(a_fifo_fill_bound, clk_i, rst_ni, cnt_q <= (FIFO_PW+1)'(FIFO_DEPTH), "queue overfilled")
  `ASSERT_IMP(a_fifo_ptr_gap, clk_i, rst_ni, cnt_q != (FIFO_PW+1)'(FIFO_DEPTH) && cnt_q != '0, wp_q != rp_q, "pointers meet while partly full")

endmodule

// File: hw/rtl/bis_back.sv
// bis_back: sorted-store sequencer (binary search, tail shift, read, clear).
// Depends on bis_pkg and assert_macros.svh; holds the store memory and result register.
`include "assert_macros.svh"
module bis_back import bis_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_ready_o,
  output logic m_valid_o,
  output res_t m_res_o,
  input  logic m_ready_i
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  back_state_e state_q, state_d;

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]      rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic               pend_q, pend_d;
  logic [VALUE_W-1:0] value_q, value_d;
  res_t               res_q, res_d;
  logic               m_valid_q;
  res_t               m_res_q;

  logic [VALUE_W-1:0] store_mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               we;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic          full, in_range, slot_free, load_out;

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[CW:1];
  assign full      = count_q == CW'(CAPACITY);
  assign in_range  = 32'(cmd_i.index) < 32'(count_q);
  assign slot_free = !m_valid_q || m_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_INSERT: state_d = full ? BS_DONE : BS_SEARCH;
            OP_READ:   state_d = in_range ? BS_READ_WAIT : BS_DONE;
            default:   state_d = BS_DONE;
          endcase
        end
      end
      BS_SEARCH: begin
        if (lo_q < hi_q) begin
          state_d = BS_COMPARE;
        end else if (lo_q == count_q) begin
          state_d = BS_PLACE;
        end else begin
          state_d = BS_SHIFT;
        end
      end
      BS_COMPARE:    state_d = BS_SEARCH;
      BS_SHIFT:      state_d = (rd_ptr_q == lo_q) ? BS_SHIFT_LAST : BS_SHIFT;
      BS_SHIFT_LAST: state_d = BS_PLACE;
      BS_PLACE:      state_d = BS_DONE;
      BS_READ_WAIT:  state_d = BS_DONE;
      BS_DONE:       state_d = slot_free ? BS_IDLE : BS_DONE;
      default:       state_d = BS_IDLE;
    endcase
  end

  // Datapath and memory port control
  always_comb begin
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    pend_d      = pend_q;
    value_d     = value_q;
    res_d       = res_q;
    rd_addr     = '0;
    wr_addr     = '0;
    wr_data     = '0;
    we          = 1'b0;
    cmd_ready_o = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      BS_IDLE: begin
        cmd_ready_o = 1'b1;
        rd_addr     = AW'(cmd_i.index);
        if (cmd_valid_i) begin
          value_d           = cmd_i.value;
          res_d.entry_value = '0;
          res_d.count       = COUNT_W'(count_q);
          res_d.status      = ST_OK;
          case (cmd_i.op)
            OP_INSERT: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                lo_d = '0;
                hi_d = count_q;
              end
            end
            OP_READ: begin
              if (!in_range) begin
                res_d.status = ST_RANGE;
              end
            end
            OP_CLEAR: begin
              count_d     = '0;
              res_d.count = '0;
            end
            default: ;
          endcase
        end
      end
      // Probe the midpoint; on convergence set up the tail shift
      BS_SEARCH: begin
        rd_addr  = mid[AW-1:0];
        mid_d    = mid;
        pend_d   = 1'b0;
        rd_ptr_d = CW'(count_q - 1'b1);
      end
      BS_COMPARE: begin
        if (rd_data_q < value_q) begin
          lo_d = CW'(mid_q + 1'b1);
        end else begin
          hi_d = mid_q;
        end
      end
      // Read entry r while writing the entry read last beat one slot up
      BS_SHIFT: begin
        rd_addr  = rd_ptr_q[AW-1:0];
        we       = pend_q;
        wr_addr  = wr_ptr_q[AW-1:0];
        wr_data  = rd_data_q;
        pend_d   = 1'b1;
        wr_ptr_d = CW'(rd_ptr_q + 1'b1);
        rd_ptr_d = CW'(rd_ptr_q - 1'b1);
      end
      BS_SHIFT_LAST: begin
        we      = 1'b1;
        wr_addr = wr_ptr_q[AW-1:0];
        wr_data = rd_data_q;
      end
      BS_PLACE: begin
        we          = 1'b1;
        wr_addr     = lo_q[AW-1:0];
        wr_data     = value_q;
        count_d     = CW'(count_q + 1'b1);
        res_d.count = COUNT_W'(count_q + 1'b1);
      end
      BS_READ_WAIT: begin
        res_d.entry_value = rd_data_q;
      end
      BS_DONE: begin
        load_out = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    value_q  <= value_d;
    res_q    <= res_d;
    if (load_out) begin
      m_res_q <= res_q;
    end
  end

  // Store memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= store_mem[rd_addr];
  end

  assign m_valid_o = m_valid_q;
  assign m_res_o   = m_res_q;

  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= CW'(CAPACITY), "count above capacity")
  `ASSERT_IMP(a_search_order, clk_i, rst_ni, state_q == BS_SEARCH, lo_q <= hi_q && hi_q <= count_q, "search bounds crossed")
  `ASSERT_IMP(a_shift_window, clk_i, rst_ni, state_q == BS_SHIFT, rd_ptr_q >= lo_q && rd_ptr_q < count_q, "shift pointer outside tail")
  `ASSERT_IMP(a_pop_idle_only, clk_i, rst_ni, cmd_ready_o, state_q == BS_IDLE, "command taken while busy")

endmodule

// File: hw/rtl/binary_insertion_sorter.sv
// binary_insertion_sorter: top level of the sorted-store block.
// Depends on bis_pkg, bis_front, bis_fifo and bis_back.
//
// Keeps up to CAPACITY 16-bit values in ascending order; every input beat
// (insert, read, clear, or an unused kind that does nothing) returns one
// result beat. Work is done one item at a time by the back-end sequencer on a
// single memory with one write and one registered read port. An insert takes
// the command, runs a binary search (a read and a compare per probe), closes
// the search, then moves each entry at or above the landing position up one
// slot, finishes the move and places the value (no move when it appends),
// and posts the result. A read takes the command, waits for the registered
// read data and posts the result; clears, unused kinds and dropped or
// out-of-range items go from taking the command straight to posting the
// result. The input register and a four-deep command queue let new beats be
// taken while the back end works. No clearing pass is run after reset; the
// store is valid as soon as reset is released.
module binary_insertion_sorter import bis_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // value[15:0], index[25:16], zero pad
  input  logic [KIND_W-1:0]      s_axis_tuser_i,  // kind[1:0]
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // entry_value[15:0], count[26:16],
                                                  // status[28:27], zero pad
);

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  res_t res;

  bis_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (front_valid),
    .cmd_o           (front_cmd),
    .cmd_ready_i     (front_ready)
  );

  bis_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_i       (front_cmd),
    .push_ready_o (front_ready),
    .pop_valid_o  (q_valid),
    .pop_o        (q_cmd),
    .pop_ready_i  (q_ready)
  );

  bis_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_ready_o (q_ready),
    .m_valid_o   (m_axis_tvalid_o),
    .m_res_o     (res),
    .m_ready_i   (m_axis_tready_i)
  );

  // Result beat packing, zero padded to whole bytes
  assign m_axis_tdata_o = {(OUT_TDATA_W - VALUE_W - COUNT_W - STATUS_W)'(0),
                           res.status, res.count, res.entry_value};

endmodule
